// ----- src/hrlm_pkg.sv -----
// ----------------------------------------------------------------------------
// hrlm_pkg
// Shared types, codes and constants of the request line matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package hrlm_pkg;

  localparam int MAX_LEN      = 4096;
  localparam int POS_W        = $clog2(MAX_LEN + 2);
  localparam int NAME_START_W = 12;
  localparam int NAME_END_W   = 13;

  // result status
  localparam logic [1:0] ST_BAD      = 2'd0;
  localparam logic [1:0] ST_OK       = 2'd1;
  localparam logic [1:0] ST_NO_NAME  = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  // method codes
  localparam logic [1:0] M_HEAD = 2'd0;
  localparam logic [1:0] M_PUT  = 2'd1;
  localparam logic [1:0] M_GET  = 2'd2;

  // method word tracker: 1..4 are letters matched so far
  localparam logic [2:0] P_UNDECIDED = 3'd0;
  localparam logic [2:0] P_ONE       = 3'd1;
  localparam logic [2:0] P_LAST_STEP = 3'd4;
  localparam logic [2:0] P_MATCHED   = 3'd5;
  localparam logic [2:0] P_FAILED    = 3'd7;

  // file name suffix tracker
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_DOT  = 3'd2;
  localparam logic [2:0] S_T    = 3'd3;
  localparam logic [2:0] S_TX   = 3'd4;

  typedef struct packed {
    logic [1:0]              status;
    logic [1:0]              method;
    logic [NAME_START_W-1:0] name_start;
    logic [NAME_END_W-1:0]   name_end;
  } hrlm_result_t;

  function automatic logic [1:0] method_of(input logic [7:0] b);
    logic [1:0] m;
    if (b == "H") m = M_HEAD;
    else if (b == "P") m = M_PUT;
    else m = M_GET;
    return m;
  endfunction

  function automatic logic [7:0] word_char(input logic [1:0] m, input logic [2:0] k);
    logic [7:0] c;
    c = 8'd0;
    unique case (m)
      M_HEAD: begin
        unique case (k)
          3'd0: c = "H";
          3'd1: c = "E";
          3'd2: c = "A";
          3'd3: c = "D";
          default: c = 8'd0;
        endcase
      end
      M_PUT: begin
        unique case (k)
          3'd0: c = "P";
          3'd1: c = "U";
          3'd2: c = "T";
          default: c = 8'd0;
        endcase
      end
      default: begin
        unique case (k)
          3'd0: c = "G";
          3'd1: c = "E";
          3'd2: c = "T";
          default: c = 8'd0;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] word_len(input logic [1:0] m);
    return (m == M_HEAD) ? 3'd4 : 3'd3;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

endpackage

`default_nettype wire

// ----- src/hrlm_if.sv -----
// ----------------------------------------------------------------------------
// hrlm_if
// Request byte channel and result channel of the request line matcher.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrlm_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface hrlm_res_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [1:0]                          method;
  logic [hrlm_pkg::NAME_START_W-1:0]   name_start;
  logic [hrlm_pkg::NAME_END_W-1:0]     name_end;

  modport source (output valid, output status, output method, output name_start,
                  output name_end, input ready);
  modport sink   (input valid, input status, input method, input name_start,
                  input name_end, output ready);
endinterface

`default_nettype wire

// ----- src/hrlm_scan.sv -----
// ----------------------------------------------------------------------------
// hrlm_scan
// Per-byte match state: method word, file name suffix, version string.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlm_scan (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  take,
  input  wire logic [7:0]            byte_in,
  input  wire logic                  last_byte,
  output hrlm_pkg::hrlm_result_t     result
);

  logic [hrlm_pkg::POS_W-1:0]        position, position_next;
  logic [2:0]                        prefix_state, prefix_state_next;
  logic [1:0]                        method, method_next;
  logic [2:0]                        suffix_state, suffix_state_next;
  logic [hrlm_pkg::NAME_START_W-1:0] run_begin, run_begin_next;
  logic                              name_found, name_found_next;
  logic [hrlm_pkg::NAME_START_W-1:0] found_start, found_start_next;
  logic [hrlm_pkg::NAME_END_W-1:0]   found_end, found_end_next;
  logic [7:0]                        recent [7];
  logic [7:0]                        recent_next [7];
  logic                              version_found, version_found_next;
  logic                              text_ended, text_ended_next;

  logic                              examine;
  logic                              letter;
  logic                              hit;
  logic [hrlm_pkg::NAME_START_W-1:0] pos_s;

  assign letter = hrlm_pkg::is_letter(byte_in);
  assign pos_s  = hrlm_pkg::NAME_START_W'(position);

  always_comb begin
    examine            = 1'b0;
    position_next      = position;
    prefix_state_next  = prefix_state;
    method_next        = method;
    suffix_state_next  = suffix_state;
    run_begin_next     = run_begin;
    name_found_next    = name_found;
    found_start_next   = found_start;
    found_end_next     = found_end;
    recent_next        = recent;
    version_found_next = version_found;
    text_ended_next    = text_ended;
    hit                = 1'b0;

    if (take && !text_ended) begin
      if (byte_in == 8'd0) begin
        text_ended_next = 1'b1;
      end else if (position >= hrlm_pkg::POS_W'(hrlm_pkg::MAX_LEN)) begin
        position_next = hrlm_pkg::POS_W'(hrlm_pkg::MAX_LEN + 1);
      end else begin
        examine       = 1'b1;
        position_next = position + 1'b1;
      end
    end

    if (examine) begin
      // method word
      if (position == '0) begin
        method_next = hrlm_pkg::method_of(byte_in);
        prefix_state_next = (byte_in == "H" || byte_in == "P" || byte_in == "G") ?
                            hrlm_pkg::P_ONE : hrlm_pkg::P_FAILED;
      end else if (prefix_state >= hrlm_pkg::P_ONE && prefix_state <= hrlm_pkg::P_LAST_STEP) begin
        if (prefix_state < hrlm_pkg::P_LAST_STEP &&
            byte_in == hrlm_pkg::word_char(method, prefix_state)) begin
          prefix_state_next = (prefix_state + 3'd1 == hrlm_pkg::word_len(method)) ?
                              hrlm_pkg::P_MATCHED : prefix_state + 3'd1;
        end else begin
          prefix_state_next = hrlm_pkg::P_FAILED;
        end
      end

      // letters then ".txt"; on a broken suffix the run restarts at the t after the dot
      if (!name_found) begin
        unique case (suffix_state)
          hrlm_pkg::S_IDLE: begin
            if (letter) begin
              run_begin_next = pos_s;
              suffix_state_next = hrlm_pkg::S_RUN;
            end
          end
          hrlm_pkg::S_RUN: begin
            if (byte_in == ".") suffix_state_next = hrlm_pkg::S_DOT;
            else if (!letter) suffix_state_next = hrlm_pkg::S_IDLE;
          end
          hrlm_pkg::S_DOT: begin
            if (byte_in == "t") begin
              suffix_state_next = hrlm_pkg::S_T;
            end else if (letter) begin
              run_begin_next = pos_s;
              suffix_state_next = hrlm_pkg::S_RUN;
            end else begin
              suffix_state_next = hrlm_pkg::S_IDLE;
            end
          end
          hrlm_pkg::S_T: begin
            if (byte_in == "x") begin
              suffix_state_next = hrlm_pkg::S_TX;
            end else if (byte_in == ".") begin
              run_begin_next = pos_s - 1'b1;
              suffix_state_next = hrlm_pkg::S_DOT;
            end else if (letter) begin
              run_begin_next = pos_s - 1'b1;
              suffix_state_next = hrlm_pkg::S_RUN;
            end else begin
              suffix_state_next = hrlm_pkg::S_IDLE;
            end
          end
          hrlm_pkg::S_TX: begin
            if (byte_in == "t") begin
              name_found_next  = 1'b1;
              found_start_next = run_begin;
              found_end_next   = hrlm_pkg::NAME_END_W'(position) + 1'b1;
            end else if (byte_in == ".") begin
              run_begin_next = pos_s - 2'd2;
              suffix_state_next = hrlm_pkg::S_DOT;
            end else if (letter) begin
              run_begin_next = pos_s - 2'd2;
              suffix_state_next = hrlm_pkg::S_RUN;
            end else begin
              suffix_state_next = hrlm_pkg::S_IDLE;
            end
          end
          default: suffix_state_next = hrlm_pkg::S_IDLE;
        endcase
      end

      // "HTTP/1" then any byte then "1"; recent[6] is the oldest byte
      hit = (byte_in == "1") && (recent[6] == "H") && (recent[5] == "T") &&
            (recent[4] == "T") && (recent[3] == "P") && (recent[2] == "/") &&
            (recent[1] == "1");
      if (hit) version_found_next = 1'b1;
      for (int i = 6; i > 0; i--) recent_next[i] = recent[i-1];
      recent_next[0] = byte_in;
    end
  end

  always_comb begin
    result = '0;
    if (position_next > hrlm_pkg::POS_W'(hrlm_pkg::MAX_LEN)) begin
      result.status = hrlm_pkg::ST_TOO_LONG;
    end else if (prefix_state_next != hrlm_pkg::P_MATCHED) begin
      result.status = hrlm_pkg::ST_BAD;
    end else if (!name_found_next) begin
      result.status = hrlm_pkg::ST_NO_NAME;
    end else if (!version_found_next) begin
      result.status = hrlm_pkg::ST_BAD;
    end else begin
      result.status     = hrlm_pkg::ST_OK;
      result.method     = method_next;
      result.name_start = found_start_next;
      result.name_end   = found_end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      position      <= '0;
      prefix_state  <= hrlm_pkg::P_UNDECIDED;
      method        <= hrlm_pkg::M_HEAD;
      suffix_state  <= hrlm_pkg::S_IDLE;
      run_begin     <= '0;
      name_found    <= 1'b0;
      found_start   <= '0;
      found_end     <= '0;
      for (int i = 0; i < 7; i++) recent[i] <= 8'd0;
      version_found <= 1'b0;
      text_ended    <= 1'b0;
    end else begin
      position      <= position_next;
      prefix_state  <= prefix_state_next;
      method        <= method_next;
      suffix_state  <= suffix_state_next;
      run_begin     <= run_begin_next;
      name_found    <= name_found_next;
      found_start   <= found_start_next;
      found_end     <= found_end_next;
      recent        <= recent_next;
      version_found <= version_found_next;
      text_ended    <= text_ended_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/http_request_line_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// http_request_line_matcher_unit
// Streaming checker of an HTTP request line, one byte per word.
// ----------------------------------------------------------------------------
// Takes one request byte per cycle, sustained, with full backpressure on both
// sides. Each byte lands in an input register and, once taken from there,
// updates a handful of small match registers (method word, file name suffix,
// version string, byte count); the result word for a request is loaded into
// the output register on the cycle its last byte is processed. Only a last
// byte whose result cannot be stored while the output register is still
// full stalls the input.
// After each result the match state starts over for the next request.
`default_nettype none

module http_request_line_matcher_unit (
  input wire logic   clk,
  input wire logic   rst,
  hrlm_req_if.sink   req,
  hrlm_res_if.source res
);

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   in_last;
  logic                   fire;
  logic                   out_valid;
  hrlm_pkg::hrlm_result_t scan_result;
  hrlm_pkg::hrlm_result_t out_word;

  // a byte without the last flag never needs the output register
  assign fire      = in_valid && (!in_last || !out_valid || res.ready);
  assign req.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_byte <= req.byte_in;
      in_last <= req.last_byte;
    end
  end

  hrlm_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .take      (fire),
    .byte_in   (in_byte),
    .last_byte (in_last),
    .result    (scan_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && in_last) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last) begin
      out_word <= scan_result;
    end
  end

  assign res.valid      = out_valid;
  assign res.status     = out_word.status;
  assign res.method     = out_word.method;
  assign res.name_start = out_word.name_start;
  assign res.name_end   = out_word.name_end;

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HTTP request line matcher. Whole requests are
// queued as bytes and streamed in with random gaps and output stalls. A
// built-in match model predicts the verdict word of every request, and each
// word that comes out is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int TAIL_LEN     = 300;   // no idling once this few bytes remain
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 1700;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } req_word_t;

  logic clk;
  logic rst;

  hrlm_req_if req_ch ();
  hrlm_res_if res_ch ();

  http_request_line_matcher_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  req_word_t              request_bytes[$];
  hrlm_pkg::hrlm_result_t pending_verdicts[$];
  logic [7:0]             draft[$];
  string                  verb_text[3] = '{"HEAD", "PUT", "GET"};
  string                  version_head = "HTTP/1";

  // match model state
  logic [12:0] byte_count;
  logic [2:0]  word_track;
  logic [7:0]  lead_byte;
  logic [2:0]  suffix_track;
  logic [11:0] cand_start;
  logic        name_seen;
  logic [11:0] name_lo;
  logic [12:0] name_hi;
  logic [7:0]  history[7];
  logic        version_seen;
  logic        after_nul;

  int mismatch_count = 0;
  int results_seen   = 0;
  int requests_built = 0;
  int random_bytes   = 0;
  int stall_cycles   = 0;
  int status_tally[4] = '{0, 0, 0, 0};
  int send_gap       = 0;
  int take_gap       = 0;
  logic calm         = 1'b0;
  logic tail         = 1'b0;
  logic long_hold    = 1'b0;

  // ---------------------------------------------------------------- model

  function automatic logic [1:0] verb_code(input logic [7:0] c);
    logic [1:0] v;
    case (c)
      "H": v = hrlm_pkg::M_HEAD;
      "P": v = hrlm_pkg::M_PUT;
      default: v = hrlm_pkg::M_GET;
    endcase
    return v;
  endfunction

  function automatic logic alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic void clear_match_state();
    byte_count   = '0;
    word_track   = hrlm_pkg::P_UNDECIDED;
    lead_byte    = '0;
    suffix_track = hrlm_pkg::S_IDLE;
    cand_start   = '0;
    name_seen    = 1'b0;
    name_lo      = '0;
    name_hi      = '0;
    foreach (history[i]) history[i] = '0;
    version_seen = 1'b0;
    after_nul    = 1'b0;
  endfunction

  function automatic void scan_text_byte(input logic [7:0] c);
    logic [12:0] pos;
    logic [1:0]  sel;
    int          k;
    logic        letter;
    logic        hit;
    pos    = byte_count;
    letter = alpha(c);

    if (pos == 0) begin
      lead_byte  = c;
      word_track = (c == "H" || c == "P" || c == "G") ?
                   hrlm_pkg::P_ONE : hrlm_pkg::P_FAILED;
    end else if (word_track >= hrlm_pkg::P_ONE && word_track <= hrlm_pkg::P_LAST_STEP) begin
      sel = verb_code(lead_byte);
      k   = word_track;
      if (k < verb_text[sel].len() && c == verb_text[sel][k])
        word_track = (k + 1 == verb_text[sel].len()) ? hrlm_pkg::P_MATCHED : 3'(k + 1);
      else
        word_track = hrlm_pkg::P_FAILED;
    end

    // name = first letter run directly followed by ".txt"
    if (!name_seen) begin
      case (suffix_track)
        hrlm_pkg::S_IDLE: begin
          if (letter) begin
            cand_start   = pos[11:0];
            suffix_track = hrlm_pkg::S_RUN;
          end
        end
        hrlm_pkg::S_RUN: begin
          if (c == ".") suffix_track = hrlm_pkg::S_DOT;
          else if (!letter) suffix_track = hrlm_pkg::S_IDLE;
        end
        hrlm_pkg::S_DOT: begin
          if (c == "t") suffix_track = hrlm_pkg::S_T;
          else if (letter) begin
            cand_start   = pos[11:0];
            suffix_track = hrlm_pkg::S_RUN;
          end else suffix_track = hrlm_pkg::S_IDLE;
        end
        hrlm_pkg::S_T: begin
          if (c == "x") suffix_track = hrlm_pkg::S_TX;
          else if (c == ".") begin
            cand_start   = 12'(pos - 13'd1);
            suffix_track = hrlm_pkg::S_DOT;
          end else if (letter) begin
            cand_start   = 12'(pos - 13'd1);
            suffix_track = hrlm_pkg::S_RUN;
          end else suffix_track = hrlm_pkg::S_IDLE;
        end
        hrlm_pkg::S_TX: begin
          if (c == "t") begin
            name_seen = 1'b1;
            name_lo   = cand_start;
            name_hi   = pos + 13'd1;
          end else if (c == ".") begin
            cand_start   = 12'(pos - 13'd2);
            suffix_track = hrlm_pkg::S_DOT;
          end else if (letter) begin
            cand_start   = 12'(pos - 13'd2);
            suffix_track = hrlm_pkg::S_RUN;
          end else suffix_track = hrlm_pkg::S_IDLE;
        end
        default: suffix_track = hrlm_pkg::S_IDLE;
      endcase
    end

    // version: "HTTP/1", any byte, then "1"
    if (!version_seen) begin
      hit = (c == "1");
      for (k = 0; k < 6; k++)
        if (history[6 - k] != version_head[k]) hit = 1'b0;
      if (hit) version_seen = 1'b1;
    end
    for (k = 6; k > 0; k--) history[k] = history[k - 1];
    history[0] = c;
  endfunction

  function automatic void match_request_byte(input logic [7:0] c, input logic fin);
    hrlm_pkg::hrlm_result_t v;
    if (!after_nul) begin
      if (c == 8'd0) after_nul = 1'b1;
      else if (byte_count >= hrlm_pkg::MAX_LEN) byte_count = 13'(hrlm_pkg::MAX_LEN + 1);
      else begin
        scan_text_byte(c);
        byte_count = byte_count + 13'd1;
      end
    end
    if (fin) begin
      v = '0;
      if (byte_count > hrlm_pkg::MAX_LEN) v.status = hrlm_pkg::ST_TOO_LONG;
      else if (word_track != hrlm_pkg::P_MATCHED) v.status = hrlm_pkg::ST_BAD;
      else if (!name_seen) v.status = hrlm_pkg::ST_NO_NAME;
      else if (!version_seen) v.status = hrlm_pkg::ST_BAD;
      else begin
        v.status     = hrlm_pkg::ST_OK;
        v.method     = verb_code(lead_byte);
        v.name_start = name_lo;
        v.name_end   = name_hi;
      end
      pending_verdicts.push_back(v);
      status_tally[v.status]++;
      clear_match_state();
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at verdict %0d: %s got %0d want %0d", results_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_verdict(input logic [1:0] st, input logic [1:0] mt,
                               input logic [11:0] lo, input logic [12:0] hi);
    hrlm_pkg::hrlm_result_t want;
    if (pending_verdicts.size() == 0) begin
      report_mismatch("unexpected word, status", st, -1);
    end else begin
      want = pending_verdicts.pop_front();
      if (st != want.status) report_mismatch("status", st, want.status);
      if (mt != want.method) report_mismatch("method", mt, want.method);
      if (lo != want.name_start) report_mismatch("name_start", lo, want.name_start);
      if (hi != want.name_end) report_mismatch("name_end", hi, want.name_end);
    end
    results_seen++;
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
  endtask

  task automatic queue_request();
    for (int i = 0; i < draft.size(); i++)
      request_bytes.push_back('{data: draft[i], fin: (i == draft.size() - 1)});
    draft.delete();
    requests_built++;
  endtask

  task automatic directed(input string s);
    add_text(s);
    queue_request();
  endtask

  function automatic logic [7:0] random_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
  endfunction

  task automatic add_letters();
    repeat ($urandom_range(1, 6)) draft.push_back(random_letter());
  endtask

  // text close to a name but mostly not one
  task automatic add_decoy();
    case ($urandom_range(0, 6))
      0: begin add_letters(); add_text(".tx"); end
      1: begin add_letters(); add_text(".t"); end
      2: begin add_letters(); add_text("."); end
      3: begin add_letters(); draft.push_back(8'($urandom_range(48, 57))); add_text(".txt"); end
      4: add_text(".txt");
      5: begin add_letters(); add_text(".t.tx.txt"); end
      default: repeat ($urandom_range(1, 3)) draft.push_back(8'($urandom_range(1, 255)));
    endcase
    add_text(" ");
  endtask

  task automatic add_version();
    case ($urandom_range(0, 5))
      0: add_text("HTTP/1.0");
      1: add_text("HTP/1.1");
      2: add_text("HTTP/11");
      default: begin
        add_text("HTTP/1");
        draft.push_back(8'($urandom_range(1, 255)));
        add_text("1");
      end
    endcase
  endtask

  task automatic build_random_request();
    if ($urandom_range(0, 4) == 0) begin
      // noise
      repeat ($urandom_range(1, 24)) draft.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) draft[0] = verb_text[$urandom_range(0, 2)][0];
    end else begin
      add_text(verb_text[$urandom_range(0, 2)]);
      if ($urandom_range(0, 9) == 0) draft[$urandom_range(0, draft.size() - 1)] = random_letter();
      add_text(" ");
      repeat ($urandom_range(0, 2)) add_decoy();
      if ($urandom_range(0, 7) != 0) begin
        add_text("/");
        add_letters();
        add_text(".txt ");
      end
      repeat ($urandom_range(0, 1)) add_decoy();
      if ($urandom_range(0, 5) == 0) add_version();
      else begin
        add_text("HTTP/1");
        draft.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'h2e);
        add_text("1");
      end
      if ($urandom_range(0, 3) == 0) add_decoy();
      if ($urandom_range(0, 9) == 0) begin
        draft.insert($urandom_range(0, draft.size()), 8'h00);
        repeat ($urandom_range(0, 4)) draft.push_back(8'($urandom_range(0, 255)));
      end
    end
    random_bytes += draft.size();
    queue_request();
  endtask

  task automatic build_directed();
    directed("GET index.txt HTTP/1.1");
    directed("HEAD a.txt HTTP/1.1");
    directed("PUT Zz.txt HTTP/1x1");
    directed("GEX a.txt HTTP/1.1");
    directed("ZET a.txt HTTP/1.1");
    directed("HEAD /a1.txt HTTP/1.1");
    directed("PUT b.txt HTTP/1.0");
    directed("GE");
    directed("HEAD");
    directed("PUT x.t.txtHTTP/1.1");
    directed("GET a..txt ab.tx.txt HTTP/1.1");
    // nul ends the text early
    add_text("GET a.txt");
    draft.push_back(8'h00);
    directed(" HTTP/1.1");
    add_text("GET a.txt HTTP/1.1");
    draft.push_back(8'h00);
    draft.push_back(8'hff);
    directed("xyz");
    draft.push_back(8'h00);
    queue_request();
    add_text("PUT ");
    draft.push_back(8'hff);
    draft.push_back(8'h80);
    add_text("Q.txt HTTP/1");
    draft.push_back(8'hff);
    directed("1");
  endtask

  // ---------------------------------------------------------------- clock, reset

  initial begin
    clk              = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.byte_in   = 8'd0;
    req_ch.last_byte = 1'b0;
    res_ch.ready     = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    logic offering;
    if (rst) begin
      req_ch.valid     <= 1'b0;
      req_ch.byte_in   <= 8'd0;
      req_ch.last_byte <= 1'b0;
      clear_match_state();
    end else begin
      offering = req_ch.valid;
      if (req_ch.valid && !req_ch.ready) stall_cycles++;
      if (req_ch.valid && req_ch.ready) begin
        match_request_byte(req_ch.byte_in, req_ch.last_byte);
        void'(request_bytes.pop_front());
        offering = 1'b0;
        if (req_ch.last_byte && $urandom_range(0, 3) == 0) calm <= ~calm;
      end
      tail <= (request_bytes.size() < TAIL_LEN);
      // a word on offer stays put until taken
      if (!offering) begin
        if (send_gap == 0 && !calm && !tail && $urandom_range(0, 11) == 0)
          send_gap = $urandom_range(1, 10);
        if (send_gap != 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (request_bytes.size() != 0) begin
          req_ch.valid     <= 1'b1;
          req_ch.byte_in   <= request_bytes[0].data;
          req_ch.last_byte <= request_bytes[0].fin;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready)
        check_verdict(res_ch.status, res_ch.method, res_ch.name_start, res_ch.name_end);
      if (take_gap == 0 && !calm && !tail && $urandom_range(0, 7) == 0)
        take_gap = $urandom_range(1, 10);
      if (take_gap != 0) take_gap--;
      res_ch.ready <= !(long_hold || take_gap != 0);
    end
  end

  // long output stall so the block backs up into its input
  initial begin
    wait (results_seen >= 25);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // ---------------------------------------------------------------- run control

  initial begin
    build_directed();
    while (random_bytes < RANDOM_BYTES) build_random_request();
    @(posedge clk);
    while (request_bytes.size() != 0 || pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests: %0d ok, %0d bad, %0d without name, %0d too long",
             requests_built, status_tally[hrlm_pkg::ST_OK], status_tally[hrlm_pkg::ST_BAD],
             status_tally[hrlm_pkg::ST_NO_NAME], status_tally[hrlm_pkg::ST_TOO_LONG]);
    $display("%0d verdicts checked, input held back for %0d cycles", results_seen,
             stall_cycles);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d bytes unsent and %0d verdicts outstanding",
             request_bytes.size(), pending_verdicts.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- http_request_line_matcher_unit.f -----
src/hrlm_pkg.sv
src/hrlm_if.sv
src/hrlm_scan.sv
src/http_request_line_matcher_unit.sv
verif/tb.sv
